@@ rtl/dfb_pkg.sv @@
// ----------------------------------------------------------------------------
// dfb_pkg: shared types and constants of the display frame builder
// Job descriptor passed from the front to the back, byte sequencer steps,
// frame constants and the reflected CRC-16 byte update.
// ----------------------------------------------------------------------------
package dfb_pkg;

  localparam int unsigned MaxPayload = 250;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoAw     = $clog2(FifoDepth);

  localparam logic [7:0]  Sync0Byte  = 8'h5A;
  localparam logic [7:0]  Sync1Byte  = 8'hA5;
  localparam logic [7:0]  ReadLen    = 8'h04;
  localparam logic [7:0]  WriteExtra = 8'd3;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'hA001;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_DATA  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_CRC_EN  = 2'd0,
    REG_WR_CMD  = 2'd1,
    REG_RD_CMD  = 2'd2,
    REG_UNUSED  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_SYNC0,
    ST_SYNC1,
    ST_LEN,
    ST_CMD,
    ST_ADDR_HI,
    ST_BODY0,
    ST_BODY1,
    ST_CRC_LO,
    ST_CRC_HI
  } step_e;

  // One unit of work for the byte sequencer.
  typedef struct packed {
    logic       rej;      // single rejected result
    logic       hdr;      // emit sync, length, command and address high
    logic [7:0] len;
    logic [7:0] cmd;
    logic [7:0] addr_hi;
    logic [7:0] b0;       // address low or payload byte
    logic       has_b1;   // read word count follows
    logic [7:0] b1;
    logic       fin;      // last covered byte closes the frame
    logic       crc_app;  // append CRC after the closing byte
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/dfb_front.sv @@
// ----------------------------------------------------------------------------
// dfb_front: input classifier
// Holds the configuration registers and the open write frame state, and
// turns each accepted input transaction into at most one sequencer job.
// ----------------------------------------------------------------------------
module dfb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_action_i,
  input  logic [15:0]       in_address_i,
  input  logic [7:0]        in_count_i,
  input  logic [7:0]        in_data_i,
  output logic              push_o,
  output dfb_pkg::job_t     job_o,
  input  logic              full_i
);

  logic       crc_en_q;
  logic [7:0] wr_cmd_q;
  logic [7:0] rd_cmd_q;
  logic       open_q, open_d;
  logic [7:0] remain_q, remain_d;
  logic       accept;
  logic [7:0] extra;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign extra      = {6'd0, crc_en_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_en_q <= 1'b1;
      wr_cmd_q <= 8'd130;
      rd_cmd_q <= 8'd131;
    end else if (cfg_valid_i) begin
      case (dfb_pkg::cfg_reg_e'(cfg_index_i))
        dfb_pkg::REG_CRC_EN: crc_en_q <= cfg_data_i[0];
        dfb_pkg::REG_WR_CMD: wr_cmd_q <= cfg_data_i;
        dfb_pkg::REG_RD_CMD: rd_cmd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    open_d          = open_q;
    remain_d        = remain_q;
    push_o          = 1'b0;
    job_o           = '0;
    job_o.addr_hi   = in_address_i[15:8];
    job_o.crc_app   = crc_en_q;
    case (dfb_pkg::action_e'(in_action_i))
      dfb_pkg::ACT_WRITE: begin
        open_d   = 1'b0;
        remain_d = 8'd0;
        push_o   = accept;
        if (in_count_i > 8'(dfb_pkg::MaxPayload)) begin
          job_o.rej = 1'b1;
        end else begin
          job_o.hdr = 1'b1;
          job_o.len = in_count_i + dfb_pkg::WriteExtra + extra;
          job_o.cmd = wr_cmd_q;
          job_o.b0  = in_address_i[7:0];
          job_o.fin = (in_count_i == 8'd0);
          if (in_count_i != 8'd0) begin
            open_d   = 1'b1;
            remain_d = in_count_i;
          end
        end
      end
      dfb_pkg::ACT_READ: begin
        open_d       = 1'b0;
        remain_d     = 8'd0;
        push_o       = accept;
        job_o.hdr    = 1'b1;
        job_o.len    = dfb_pkg::ReadLen + extra;
        job_o.cmd    = rd_cmd_q;
        job_o.b0     = in_address_i[7:0];
        job_o.has_b1 = 1'b1;
        job_o.b1     = in_count_i;
        job_o.fin    = 1'b1;
      end
      dfb_pkg::ACT_DATA: begin
        // drop data bytes outside an open write frame
        if (open_q) begin
          push_o    = accept;
          job_o.b0  = in_data_i;
          job_o.fin = (remain_q <= 8'd1);
          if (remain_q <= 8'd1) begin
            open_d   = 1'b0;
            remain_d = 8'd0;
          end else begin
            remain_d = remain_q - 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      remain_q <= 8'd0;
    end else if (accept) begin
      open_q   <= open_d;
      remain_q <= remain_d;
    end
  end

endmodule

@@ rtl/dfb_fifo.sv @@
// ----------------------------------------------------------------------------
// dfb_fifo: job queue
// Short first-word-fall-through queue between the classifier and the
// byte sequencer.
// ----------------------------------------------------------------------------
module dfb_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dfb_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output dfb_pkg::job_t head_o
);

  dfb_pkg::job_t                mem_q [dfb_pkg::FifoDepth];
  logic [dfb_pkg::FifoAw-1:0]   wr_ptr_q;
  logic [dfb_pkg::FifoAw-1:0]   rd_ptr_q;
  logic [dfb_pkg::FifoAw:0]     cnt_q;
  logic                         do_push;
  logic                         do_pop;

  assign full_o  = (cnt_q == (dfb_pkg::FifoAw+1)'(dfb_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/dfb_back.sv @@
// ----------------------------------------------------------------------------
// dfb_back: byte sequencer
// Walks each queued job byte by byte into the output register and keeps
// the running CRC over the command, address, count and payload bytes.
// ----------------------------------------------------------------------------
module dfb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  dfb_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o,
  output logic          out_rej_o
);

  dfb_pkg::step_e step_q, step_d, cur_step;
  logic           busy_q, busy_d;
  logic [15:0]    crc_q, crc_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_byte_q, out_byte_d;
  logic           out_last_q, out_last_d;
  logic           out_rej_q, out_rej_d;
  logic           load;
  logic           crc_tail;

  assign load     = !empty_i && (!out_valid_q || out_ready_i);
  assign cur_step = busy_q ? step_q :
                    (job_i.hdr ? dfb_pkg::ST_SYNC0 : dfb_pkg::ST_BODY0);
  assign crc_tail = job_i.fin && job_i.crc_app;

  always_comb begin
    step_d      = step_q;
    busy_d      = busy_q;
    crc_d       = crc_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_rej_d   = out_rej_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b0;
      out_rej_d   = 1'b0;
      busy_d      = 1'b1;
      if (job_i.rej) begin
        out_byte_d = 8'd0;
        out_rej_d  = 1'b1;
        busy_d     = 1'b0;
        pop_o      = 1'b1;
      end else begin
        case (cur_step)
          dfb_pkg::ST_SYNC0: begin
            out_byte_d = dfb_pkg::Sync0Byte;
            step_d     = dfb_pkg::ST_SYNC1;
          end
          dfb_pkg::ST_SYNC1: begin
            out_byte_d = dfb_pkg::Sync1Byte;
            step_d     = dfb_pkg::ST_LEN;
          end
          dfb_pkg::ST_LEN: begin
            out_byte_d = job_i.len;
            step_d     = dfb_pkg::ST_CMD;
          end
          dfb_pkg::ST_CMD: begin
            // restart the CRC at the command byte
            out_byte_d = job_i.cmd;
            crc_d      = dfb_pkg::crc_byte(dfb_pkg::CrcInit, job_i.cmd);
            step_d     = dfb_pkg::ST_ADDR_HI;
          end
          dfb_pkg::ST_ADDR_HI: begin
            out_byte_d = job_i.addr_hi;
            crc_d      = dfb_pkg::crc_byte(crc_q, job_i.addr_hi);
            step_d     = dfb_pkg::ST_BODY0;
          end
          dfb_pkg::ST_BODY0: begin
            out_byte_d = job_i.b0;
            crc_d      = dfb_pkg::crc_byte(crc_q, job_i.b0);
            if (job_i.has_b1) begin
              step_d = dfb_pkg::ST_BODY1;
            end else if (crc_tail) begin
              step_d = dfb_pkg::ST_CRC_LO;
            end else begin
              out_last_d = job_i.fin;
              busy_d     = 1'b0;
              pop_o      = 1'b1;
            end
          end
          dfb_pkg::ST_BODY1: begin
            out_byte_d = job_i.b1;
            crc_d      = dfb_pkg::crc_byte(crc_q, job_i.b1);
            if (crc_tail) begin
              step_d = dfb_pkg::ST_CRC_LO;
            end else begin
              out_last_d = job_i.fin;
              busy_d     = 1'b0;
              pop_o      = 1'b1;
            end
          end
          dfb_pkg::ST_CRC_LO: begin
            out_byte_d = crc_q[7:0];
            step_d     = dfb_pkg::ST_CRC_HI;
          end
          dfb_pkg::ST_CRC_HI: begin
            out_byte_d = crc_q[15:8];
            out_last_d = 1'b1;
            busy_d     = 1'b0;
            pop_o      = 1'b1;
          end
          default: begin
            busy_d = 1'b0;
            pop_o  = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= dfb_pkg::ST_SYNC0;
      busy_q      <= 1'b0;
      crc_q       <= dfb_pkg::CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      busy_q      <= busy_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_rej_q  <= out_rej_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_rej_o   = out_rej_q;

  a_rej_no_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rej_q |-> !out_last_q && (out_byte_q == 8'd0))
    else $error("rejected result carries frame end or data");

  a_busy_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !empty_i)
    else $error("sequencer mid-job with empty queue");

  a_crc_hi_follows_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && busy_q && (step_q == dfb_pkg::ST_CRC_HI) |-> $past(busy_q))
    else $error("CRC high byte without preceding low byte");

endmodule

@@ rtl/display_frame_builder_crc16.sv @@
// ----------------------------------------------------------------------------
// display_frame_builder_crc16: serial display command frame builder
// Takes write headers, read requests and payload bytes and streams out the
// framed bytes (0x5A, 0xA5, length, command, address high/low, payload,
// optional CRC-16 low then high) for a serial display UART. Each input
// transaction is classified and queued as a job; a sequencer then emits
// one byte per cycle from its output register while m_axis_tready is
// high: one byte per payload job, six per write header, seven per read
// request, and two CRC bytes after the closing byte when CRC is on.
// Input is accepted every cycle while the four-entry job queue has room;
// the output byte rate is the limit. Configuration writes are taken at
// any time and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module display_frame_builder_crc16 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // address[15:0], count[23:16], data_byte[31:24]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // tx_byte[7:0]
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser    // rejected[0]
);

  logic          push;
  dfb_pkg::job_t push_job;
  logic          full;
  logic          pop;
  logic          empty;
  dfb_pkg::job_t head_job;

  assign cfg_ready_o = 1'b1;

  dfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_action_i  (s_axis_tuser),
    .in_address_i (s_axis_tdata[15:0]),
    .in_count_i   (s_axis_tdata[23:16]),
    .in_data_i    (s_axis_tdata[31:24]),
    .push_o       (push),
    .job_o        (push_job),
    .full_i       (full)
  );

  dfb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head_job)
  );

  dfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_rej_o   (m_axis_tuser[0])
  );

endmodule
